@@ rtl/tea_pkg.sv @@
`timescale 1ns / 1ps

package tea_pkg;

    localparam int DEFAULT_MAX_POINTS = 16384;

    // field widths
    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 14;
    localparam int RLEN_W   = 15;
    localparam int IGN_W    = 14;
    localparam int SWEEP_W  = 16;
    localparam int Q_W      = 32;
    localparam int OUT_W    = 48;
    localparam int ACC_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_TOTAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = 3'd4;

    localparam logic [RLEN_W-1:0]  RST_SWEEP_LENGTH = 15'd16384;
    localparam logic [IGN_W-1:0]   RST_IGNORE_COUNT = 14'd0;
    localparam logic [SWEEP_W-1:0] RST_SWEEP_TOTAL  = 16'd1;
    localparam logic [Q_W-1:0]     RST_GAIN         = 32'd65536;
    localparam logic [Q_W-1:0]     RST_LEVEL_OFFSET = 32'd0;

    localparam logic [SAMPLE_W-1:0] CLIP_HIGH = 16'd65300;
    localparam logic [SAMPLE_W-1:0] CLIP_LOW  = 16'd235;
    localparam logic [FRAC_W-1:0]   FRAC_MAX  = 16'hFFFF;

    // front queue, power of two
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    point_index;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] scaled_value;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic [RLEN_W-1:0]     sweep_length;
        logic [IGN_W-1:0]      ignore_count;
        logic [SWEEP_W-1:0]    sweep_total;
        logic signed [Q_W-1:0] gain;
        logic signed [Q_W-1:0] level_offset;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_ADD,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    point_index;
        logic                in_range;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef struct packed {
        logic clearing;
        logic reading;
    } t_back_stat;

endpackage

@@ rtl/tea_front.sv @@
`timescale 1ns / 1ps

module tea_front
    import tea_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    input  logic        i_hold,
    output t_queue_head o_head,
    input  logic        i_pop
);

    localparam int QPW = $clog2(QUEUE_DEPTH);

    t_item          r_q_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QPW:0]   r_count;

    t_item item;
    logic  keep;
    logic  accept;
    logic  push;

    always_comb begin
        item.sample      = i_in_data.sample;
        item.point_index = i_in_data.point_index;
        item.in_range    = 32'(i_in_data.point_index) < 32'(MAX_POINTS);
        item.kind        = KIND_CLEAR;
        keep             = 1'b1;
        unique case (i_in_data.command)
            CMD_CLEAR: item.kind = KIND_CLEAR;
            CMD_ADD:   item.kind = KIND_ADD;
            CMD_READ:  item.kind = KIND_READ;
            default:   keep = 1'b0;  // no-op command is dropped here
        endcase
    end

    assign o_in_stall = i_hold || (r_count == (QPW+1)'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = accept && keep;

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/tea_back.sv @@
`timescale 1ns / 1ps

module tea_back
    import tea_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_queue_head i_head,
    output logic        o_pop,
    output t_back_stat  o_stat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int LW = (AW + 1 > RLEN_W) ? AW + 1 : RLEN_W;
    localparam int IW = (AW > IDX_W) ? AW : IDX_W;
    localparam int DCW = $clog2(FRAC_W);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_RD_WAIT,
        ST_DIV,
        ST_MUL_OFF,
        ST_MUL_FRAC,
        ST_SUB
    } t_state;

    logic [ACC_W-1:0] mem [MAX_POINTS];
    logic [ACC_W-1:0] r_mem_q;

    t_state              r_state;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_pos;
    logic                r_clip;
    logic [AW-1:0]       r_k;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_rd_zero;
    logic [ACC_W-1:0]    r_div;
    logic [ACC_W-1:0]    r_rem;
    logic [FRAC_W-1:0]   r_frac;
    logic [DCW-1:0]      r_div_cnt;
    logic [PROD_W-1:0]   r_p;
    logic [PROD_W-1:0]   r_q;
    logic                r_out_valid;
    t_out                r_out_data;

    logic [LW-1:0]       rlen;
    logic [LW-1:0]       len;
    logic [LW-1:0]       pos_cur;
    logic [LW-1:0]       pos_nxt;
    logic [LW-1:0]       ign;
    logic [LW-1:0]       k_full;
    logic                keep;
    logic [IW-1:0]       idx_ext;
    logic [SWEEP_W-1:0]  sweeps;
    logic [ACC_W-1:0]    divisor;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ACC_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic [ACC_W:0]      add_sum;
    logic [ACC_W-1:0]    add_sat;
    logic                clip_hit;
    logic [ACC_W-1:0]    rd_sum;
    logic [ACC_W:0]      rem_sh;
    logic [ACC_W:0]      rem_sub;
    logic                qbit;
    logic signed [FRAC_W+CFG_DATA_W:0] mul_b_pad;
    logic signed [Q_W:0]               mul_b;
    logic signed [PROD_W:0]            mul;
    logic [PROD_W-1:0]   prod;
    logic                out_free;
    logic                out_load;

    // effective sweep geometry
    always_comb begin
        rlen = LW'(i_cfg.sweep_length);
        if (rlen == '0) begin
            len = LW'(1);
        end else if (rlen > LW'(MAX_POINTS)) begin
            len = LW'(MAX_POINTS);
        end else begin
            len = rlen;
        end
        pos_cur = (LW'(r_pos) >= len) ? '0 : LW'(r_pos);
        pos_nxt = pos_cur + 1'b1;
        ign     = LW'(i_cfg.ignore_count);
        keep    = pos_cur >= ign;
        k_full  = pos_cur - ign;
        idx_ext = IW'(i_head.item.point_index);
        sweeps  = (i_cfg.sweep_total == '0) ? SWEEP_W'(1) : i_cfg.sweep_total;
        // sweeps * 65535
        divisor = {sweeps, {FRAC_W{1'b0}}} - ACC_W'(sweeps);
    end

    assign o_pop = (r_state == ST_IDLE) && i_head.valid;

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = idx_ext[AW-1:0];
        if (o_pop) begin
            unique case (i_head.item.kind)
                KIND_ADD: begin
                    mem_re    = keep;
                    mem_raddr = k_full[AW-1:0];
                end
                KIND_READ: mem_re = i_head.item.in_range;
                default:   mem_re = 1'b0;
            endcase
        end
    end

    assign add_sum  = {1'b0, r_mem_q} + (ACC_W+1)'(r_sample);
    assign add_sat  = add_sum[ACC_W] ? '1 : add_sum[ACC_W-1:0];
    assign clip_hit = (r_sample > CLIP_HIGH) || (r_sample < CLIP_LOW);

    assign mem_we    = (r_state == ST_CLEAR) || (r_state == ST_ADD);
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_k;
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 : add_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    // restoring division, one quotient bit per cycle
    assign rd_sum  = r_rd_zero ? '0 : r_mem_q;
    assign rem_sh  = {r_rem, 1'b0};
    assign qbit    = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    // one shared multiplier: gain * offset, then gain * fraction
    assign mul_b_pad = (r_state == ST_MUL_OFF)
                     ? (FRAC_W+CFG_DATA_W+1)'(i_cfg.level_offset)
                     : $signed({{(CFG_DATA_W+1){1'b0}}, r_frac});
    assign mul_b = mul_b_pad[Q_W:0];
    assign mul   = i_cfg.gain * mul_b;
    assign prod  = r_q - r_p;

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == ST_SUB) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pos       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MAX_POINTS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_head.valid) begin
                        unique case (i_head.item.kind)
                            KIND_CLEAR: begin
                                r_clip     <= 1'b0;
                                r_pos      <= '0;
                                r_clr_addr <= '0;
                                r_state    <= ST_CLEAR;
                            end
                            KIND_ADD: begin
                                r_pos    <= (pos_nxt >= len) ? '0 : pos_nxt[AW-1:0];
                                r_k      <= k_full[AW-1:0];
                                r_sample <= i_head.item.sample;
                                if (keep) begin
                                    r_state <= ST_ADD;
                                end
                            end
                            KIND_READ: begin
                                r_rd_zero <= !i_head.item.in_range;
                                r_div     <= divisor;
                                r_state   <= ST_RD_WAIT;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (clip_hit) begin
                        r_clip <= 1'b1;
                    end
                    r_state <= ST_IDLE;
                end
                ST_RD_WAIT: begin
                    r_div_cnt <= '0;
                    if (rd_sum >= r_div) begin
                        // fraction saturates at full scale
                        r_frac  <= FRAC_MAX;
                        r_state <= ST_MUL_OFF;
                    end else begin
                        r_frac  <= '0;
                        r_rem   <= rd_sum;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem     <= qbit ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
                    r_frac    <= {r_frac[FRAC_W-2:0], qbit};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DCW'(FRAC_W - 1)) begin
                        r_state <= ST_MUL_OFF;
                    end
                end
                ST_MUL_OFF: begin
                    r_p     <= mul[PROD_W-1:0];
                    r_state <= ST_MUL_FRAC;
                end
                ST_MUL_FRAC: begin
                    r_q     <= mul[PROD_W-1:0];
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    if (out_free) begin
                        r_out_data.scaled_value <= $signed(prod[PROD_W-1:FRAC_W]);
                        r_out_data.saturated    <= r_clip;
                        r_state                 <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_stat.reading  = (r_state == ST_SUB);
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

@@ rtl/trace_ensemble_averager.sv @@
`timescale 1ns / 1ps
// Add: enters the queue, then the back end reads the accumulator and writes it back (read, write back).
// Read: when the point saturates the fraction divider is skipped, else it runs;
//   the 16-step fraction divider and the shared multiplier form the result.
// Clear: the back end clears all MAX_POINTS accumulators, one accumulator written per cycle.
// Reset (sync, active low): a clearing pass over all MAX_POINTS accumulators runs, input stalled.
module trace_ensemble_averager
    import tea_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg        r_cfg;
    t_queue_head head;
    logic        pop;
    t_back_stat  stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sweep_length <= RST_SWEEP_LENGTH;
            r_cfg.ignore_count <= RST_IGNORE_COUNT;
            r_cfg.sweep_total  <= RST_SWEEP_TOTAL;
            r_cfg.gain         <= $signed(RST_GAIN);
            r_cfg.level_offset <= $signed(RST_LEVEL_OFFSET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SWEEP_LENGTH: r_cfg.sweep_length <= i_cfg_wdata[RLEN_W-1:0];
                REG_IGNORE_COUNT: r_cfg.ignore_count <= i_cfg_wdata[IGN_W-1:0];
                REG_SWEEP_TOTAL:  r_cfg.sweep_total  <= i_cfg_wdata[SWEEP_W-1:0];
                REG_GAIN:         r_cfg.gain         <= $signed(i_cfg_wdata[Q_W-1:0]);
                REG_LEVEL_OFFSET: r_cfg.level_offset <= $signed(i_cfg_wdata[Q_W-1:0]);
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    tea_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_hold     (stat.clearing),
        .o_head     (head),
        .i_pop      (pop)
    );

    tea_back #(
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("back end popped an empty queue");

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !pop)
        else $error("item taken during clearing pass");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(stat.reading))
        else $error("result raised outside the read path");

    a_stall_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> o_in_stall)
        else $error("input not stalled during clearing pass");

endmodule

@@ sim/trace_ensemble_averager_tb.sv @@
`timescale 1ns / 1ps

module trace_ensemble_averager_tb;
    import tea_pkg::*;

    localparam int POINTS        = DEFAULT_MAX_POINTS;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    // the one command code the block drops without effect
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // shadow of the block
    t_cfg        model_cfg;
    logic [31:0] acc_model [0:POINTS-1];
    int unsigned sweep_pos;
    bit          clip_seen;

    t_in  beat_backlog[$];
    t_out expected_points[$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          phase_no      = 0;
    int          hold_ticket   = 0;
    int          hold_seen     = 0;
    int unsigned hold_left     = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;

    trace_ensemble_averager i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // advance the shadow store by one accepted beat; a read queues its scaled point
    task automatic track_beat(t_in b);
        int unsigned        len;
        int unsigned        pos;
        int unsigned        k;
        logic [32:0]        total;
        logic [31:0]        sum;
        logic [63:0]        divisor;
        logic [63:0]        frac;
        logic signed [65:0] frac_s;
        logic signed [65:0] gain_s;
        logic signed [65:0] ofs_s;
        logic signed [65:0] prod;
        t_out               point;
        case (b.command)
            CMD_CLEAR: begin
                foreach (acc_model[i]) acc_model[i] = '0;
                clip_seen = 1'b0;
                sweep_pos = 0;
            end
            CMD_ADD: begin
                len = model_cfg.sweep_length;
                if (len == 0) len = 1;
                if (len > POINTS) len = POINTS;
                pos = sweep_pos;
                if (pos >= len) pos = 0;
                if (pos >= model_cfg.ignore_count) begin
                    k = pos - model_cfg.ignore_count;
                    total = acc_model[k] + b.sample;
                    acc_model[k] = total[32] ? 32'hFFFF_FFFF : total[31:0];
                    if (b.sample > CLIP_HIGH || b.sample < CLIP_LOW) clip_seen = 1'b1;
                end
                pos++;
                sweep_pos = (pos >= len) ? 0 : pos;
            end
            CMD_READ: begin
                sum = acc_model[b.point_index];
                divisor = ((model_cfg.sweep_total == 0) ? 64'd1 : 64'(model_cfg.sweep_total))
                          * 64'd65535;
                frac = {16'd0, sum, 16'd0} / divisor;
                if (frac > 64'd65535) frac = 64'd65535;
                frac_s = $signed({50'd0, frac[15:0]});
                gain_s = $signed(model_cfg.gain);
                ofs_s  = $signed(model_cfg.level_offset);
                prod   = gain_s * (frac_s - ofs_s);
                point.scaled_value = prod[63:16];
                point.saturated    = clip_seen;
                expected_points.push_back(point);
            end
            default: ;
        endcase
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) track_beat(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (beat_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data  <= beat_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall, with a long hold-off whenever the ticket moves
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            hold_seen   <= 0;
        end else if (hold_seen != hold_ticket) begin
            hold_seen   <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected point", $signed(o_out_data.scaled_value), 0);
            end else begin
                want = expected_points.pop_front();
                if (o_out_data.scaled_value !== want.scaled_value)
                    report_mismatch("scaled_value", $signed(o_out_data.scaled_value),
                                    $signed(want.scaled_value));
                if (o_out_data.saturated !== want.saturated)
                    report_mismatch("saturated", o_out_data.saturated, want.saturated);
            end
        end
    end

    function automatic t_in pack_beat(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] s,
                                      logic [IDX_W-1:0] idx);
        t_in b;
        b.command     = cmd;
        b.sample      = s;
        b.point_index = idx;
        return b;
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return SAMPLE_W'($urandom_range(0, 240));
        if (pick < 30) return SAMPLE_W'($urandom_range(65295, 65535));
        return SAMPLE_W'($urandom);
    endfunction

    // mostly inside the kept part of the sweep, a little past its end
    function automatic logic [IDX_W-1:0] kept_index(int unsigned span);
        int unsigned idx;
        idx = $urandom_range(0, span + 1);
        if (idx > POINTS - 1) idx = POINTS - 1;
        return IDX_W'(idx);
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0004_0000);
            2:       return 32'd0 - $urandom_range(0, 32'h0004_0000);
            default: return $urandom_range(0, 32'h0000_FFFF);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_SWEEP_LENGTH: model_cfg.sweep_length = value[RLEN_W-1:0];
            REG_IGNORE_COUNT: model_cfg.ignore_count = value[IGN_W-1:0];
            REG_SWEEP_TOTAL:  model_cfg.sweep_total  = value[SWEEP_W-1:0];
            REG_GAIN:         model_cfg.gain         = value;
            REG_LEVEL_OFFSET: model_cfg.level_offset = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (beat_backlog.size() != 0 || i_in_valid || expected_points.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] len, logic [31:0] ign, logic [31:0] sweeps,
                             logic [31:0] gain, logic [31:0] ofs);
        drain();
        write_reg(REG_SWEEP_LENGTH, len);
        write_reg(REG_IGNORE_COUNT, ign);
        write_reg(REG_SWEEP_TOTAL, sweeps);
        write_reg(REG_GAIN, gain);
        write_reg(REG_LEVEL_OFFSET, ofs);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phase_no++;
        if (phase_no < 5) begin
            send_idle_pct = 33;
            recv_idle_pct = 60;
        end else if (phase_no < 10) begin
            send_idle_pct = 60;
            recv_idle_pct = 33;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] len, logic [31:0] ign, logic [31:0] sweeps,
                             logic [31:0] gain, logic [31:0] ofs, int n_items,
                             bit with_clear, bit squeeze);
        int unsigned eff;
        int unsigned span;
        int unsigned chunk;
        int          count;
        int          pick;
        configure(len, ign, sweeps, gain, ofs);
        eff = len[RLEN_W-1:0];
        if (eff == 0) eff = 1;
        if (eff > POINTS) eff = POINTS;
        span  = (eff > ign[IGN_W-1:0]) ? eff - ign[IGN_W-1:0] : 1;
        chunk = (eff > 48) ? 48 : eff;
        count = 0;
        if (with_clear)
            beat_backlog.push_back(pack_beat(CMD_CLEAR, SAMPLE_W'($urandom),
                                             IDX_W'($urandom)));
        if (squeeze) begin
            // results back up while the receiver holds off
            hold_ticket++;
            repeat (30) beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom),
                                                         kept_index(span)));
            count += 30;
        end
        while (count < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                repeat (chunk) beat_backlog.push_back(pack_beat(CMD_ADD, draw_sample(),
                                                                IDX_W'($urandom)));
                count += chunk;
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) begin
                    beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom),
                                                     kept_index(span)));
                    count++;
                end
            end else if (pick < 94) begin
                // stray add that breaks sweep alignment
                beat_backlog.push_back(pack_beat(CMD_ADD, draw_sample(), IDX_W'($urandom)));
                count++;
            end else if (pick < 97) begin
                beat_backlog.push_back(pack_beat(CMD_IGNORED, SAMPLE_W'($urandom),
                                                 IDX_W'($urandom)));
            end else begin
                beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom),
                                                 IDX_W'($urandom)));
                count++;
            end
        end
        beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom), kept_index(span)));
    endtask

    initial begin
        int unsigned r_len;
        int unsigned r_ign;
        int unsigned r_sweeps;

        model_cfg.sweep_length = RST_SWEEP_LENGTH;
        model_cfg.ignore_count = RST_IGNORE_COUNT;
        model_cfg.sweep_total  = RST_SWEEP_TOTAL;
        model_cfg.gain         = RST_GAIN;
        model_cfg.level_offset = RST_LEVEL_OFFSET;
        foreach (acc_model[i]) acc_model[i] = '0;
        sweep_pos = 0;
        clip_seen = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 60;
        @(negedge i_clk);

        // directed: reset settings, edges of the clip window, full-scale point
        beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom), 14'd0));
        beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom), 14'h3FFF));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'd0, IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'hFFFF, IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'd234, IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'd235, IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'd65300, IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'd65301, IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_IGNORED, SAMPLE_W'($urandom), IDX_W'($urandom)));
        for (int i = 0; i < 6; i++)
            beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom), IDX_W'(i)));
        beat_backlog.push_back(pack_beat(CMD_CLEAR, SAMPLE_W'($urandom), IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom), 14'd1));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'd1000, IDX_W'($urandom)));
        beat_backlog.push_back(pack_beat(CMD_ADD, 16'd40000, IDX_W'($urandom)));
        // read in the middle of a sweep
        beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom), 14'd1));
        beat_backlog.push_back(pack_beat(CMD_READ, SAMPLE_W'($urandom), 14'd0));

        run_phase(8, 2, 3, 32'h0001_0000, 32'd0, 60, 1'b1, 1'b0);
        // zero length and zero sweep total, gain and offset at opposite extremes
        run_phase(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 60, 1'b0, 1'b0);
        run_phase(32'h7FFF, 16383, 65535, 32'h8000_0000, 32'h7FFF_FFFF, 40, 1'b0, 1'b0);
        // everything ignored, position still moves
        run_phase(5, 9, 2, pick_q16(), pick_q16(), 50, 1'b1, 1'b0);
        run_phase(16384, 0, 1, pick_q16(), pick_q16(), 60, 1'b1, 1'b0);
        run_phase(1, 0, 65535, 32'hFFFF_0000, pick_q16(), 60, 1'b0, 1'b0);

        for (int p = 0; p < 8; p++) begin
            r_len = $urandom_range(1, 32);
            r_ign = ($urandom_range(3) == 0) ? $urandom_range(0, r_len + 2)
                                             : $urandom_range(0, r_len / 4);
            r_sweeps = ($urandom_range(3) == 0) ? $urandom_range(1, 65535)
                                                : $urandom_range(1, 4);
            run_phase(r_len, r_ign, r_sweeps, pick_q16(), pick_q16(), 60,
                      1'($urandom_range(1)), p == 5);
        end

        drain();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
